// ===== hdl/strongly_connected_components_macros.svh =====
// Assertion helpers for the block's top module.
`ifndef STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== hdl/scc_pkg.sv =====
package scc_pkg;
  localparam int unsigned MaxNodes = 32;
  localparam int unsigned IdxW = $clog2(MaxNodes);
  localparam int unsigned NodeW = 6;
  localparam int unsigned CompW = 5;

  localparam logic [1:0] CmdAdd = 2'd0;
  localparam logic [1:0] CmdRemove = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;
  localparam logic [1:0] CmdCompute = 2'd3;

  localparam logic [0:0] RegNodeCount = 1'b0;

  // One result request from the engine toward the output stage.
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [CompW-1:0] comp;
    logic             eoc;
    logic             last;
  } result_t;
endpackage

// ===== hdl/strongly_connected_components.sv =====
// Channel  | Direction | Signals
// request  | in        | cmd_i, from_node_i, to_node_i, valid_i / ready_o
// result   | out       | node_o, component_index_o, end_of_component_o, last_o, valid_o / ready_i
// config   | in        | APB: psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Add and remove go through accept, row read and write back; clear writes one matrix row
// per cycle after the accept. Pass one scans a whole row per search step; pass two tests
// one transposed candidate per step, through StP2Next, StP2Rd and StP2Scan.
// Reset clears the matrix row by row, and no request is taken until it is done.
// A stalled result holds the engine until the single output register drains.
module strongly_connected_components (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [1:0]                  cmd_i,
  input  logic [scc_pkg::NodeW-1:0]   from_node_i,
  input  logic [scc_pkg::NodeW-1:0]   to_node_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [scc_pkg::NodeW-1:0]   node_o,
  output logic [scc_pkg::CompW-1:0]   component_index_o,
  output logic                        end_of_component_o,
  output logic                        last_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  `include "strongly_connected_components_macros.svh"

  localparam int unsigned N = scc_pkg::MaxNodes;
  localparam int unsigned IW = scc_pkg::IdxW;
  localparam int unsigned NW = scc_pkg::NodeW;

  typedef enum logic [3:0] {
    StInit, StIdle, StEditRd, StEditWr, StClear,
    StP1Start, StP1Rd, StP1Scan, StP2Pop, StP2Rd, StP2Scan, StP2Next
  } state_e;

  state_e state_q;
  logic [NW-1:0] ncount_q;
  logic [NW-1:0] n_eff;
  logic [IW:0]   sweep_q;
  logic [1:0]    cmd_q;
  logic [NW-1:0] a_q, b_q;
  logic [N-1:0]  visited_q;
  logic [NW-1:0] root_q;          // next start node for pass one
  logic [NW-1:0] snode_q [N];     // search stack nodes
  logic [NW-1:0] spos_q [N];      // search stack scan positions
  logic [IW:0]   sdepth_q;
  logic [NW-1:0] fstack_q [N];    // finishing order
  logic [IW:0]   fcount_q;
  logic [scc_pkg::CompW-1:0] comp_q;
  logic          any_q;           // a result is held back to know its flags
  scc_pkg::result_t pend_q;
  scc_pkg::result_t out_q;
  logic          ovalid_q;

  // Matrix memory.
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [N-1:0]  wdata, rdata;

  scc_ram #(.Width(N), .Depth(N)) u_adj (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign n_eff = (ncount_q > NW'(N)) ? NW'(N) : ncount_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == scc_pkg::RegNodeCount) ? {{(32-NW){1'b0}}, ncount_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncount_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == scc_pkg::RegNodeCount) begin
      ncount_q <= pwdata[NW-1:0];
    end
  end

  // Top of search stack and its scan of the row just read.
  logic [IW-1:0] top;
  logic [NW-1:0] tnode, tpos;
  logic [N-1:0]  colbits;
  logic          found;
  logic [NW-1:0] fnd;
  assign top = IW'(sdepth_q - 1'b1);
  assign tnode = snode_q[top];
  assign tpos = spos_q[top];

  // In pass two the row read is the transpose: column of node tnode, held in a row
  // memory, so pass two reads row u instead and we scan one u per step (see below).
  always_comb begin
    found = 1'b0;
    fnd = '0;
    for (int u = N; u >= 1; u--) begin
      if (NW'(u) > tpos && NW'(u) <= n_eff && rdata[u-1] && !visited_q[u-1]) begin
        found = 1'b1;
        fnd = NW'(u);
      end
    end
  end
  assign colbits = rdata;

  // Pass two: node popped from the finishing order, and the transposed edge test.
  logic [NW-1:0] pop_node;
  logic          pop_new;
  logic          scan_hit;
  assign pop_node = fstack_q[IW'(fcount_q - 1'b1)];
  assign pop_new = !visited_q[IW'(pop_node - 1'b1)];
  assign scan_hit = colbits[IW'(tnode - 1'b1)] && !visited_q[IW'(tpos)];

  logic ostall;
  logic out_load;
  assign ostall = ovalid_q && !ready_i;
  // The held-back result moves to the output register whenever a new node is found or
  // the computation ends.
  assign out_load = !ostall && any_q &&
                    (((state_q == StP2Pop) && ((fcount_q == '0) || pop_new)) ||
                     ((state_q == StP2Scan) && scan_hit));
  assign ready_o = (state_q == StIdle);
  assign valid_o = ovalid_q;
  assign node_o = out_q.node;
  assign component_index_o = out_q.comp;
  assign end_of_component_o = out_q.eoc;
  assign last_o = out_q.last;

  always_comb begin
    we = 1'b0;
    waddr = IW'(a_q - 1'b1);
    wdata = rdata;
    raddr = IW'(a_q - 1'b1);
    unique case (state_q)
      StInit: begin
        we = 1'b1; waddr = sweep_q[IW-1:0]; wdata = '0;
      end
      StClear: begin
        we = 1'b1; waddr = sweep_q[IW-1:0]; wdata = '0;
      end
      StEditWr: begin
        we = 1'b1;
        wdata = (cmd_q == scc_pkg::CmdAdd) ? (rdata | (N'(1) << (b_q - 1'b1)))
                                           : (rdata & ~(N'(1) << (b_q - 1'b1)));
      end
      StP1Start, StP1Rd: raddr = IW'(tnode - 1'b1);
      // Row of candidate u = tpos+1, held while the scan waits on the output.
      StP2Rd, StP2Scan: raddr = IW'(tpos);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      sweep_q <= '0;
      sdepth_q <= '0;
      fcount_q <= '0;
      visited_q <= '0;
      ovalid_q <= 1'b0;
      any_q <= 1'b0;
      comp_q <= '0;
    end else begin
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        StInit: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == (IW+1)'(N - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (valid_i) begin
            cmd_q <= cmd_i; a_q <= from_node_i; b_q <= to_node_i;
            unique case (cmd_i)
              scc_pkg::CmdAdd, scc_pkg::CmdRemove: begin
                if (from_node_i != '0 && to_node_i != '0 &&
                    from_node_i <= n_eff && to_node_i <= n_eff) state_q <= StEditRd;
              end
              scc_pkg::CmdClear: begin
                sweep_q <= '0; state_q <= StClear;
              end
              default: begin
                visited_q <= '0; fcount_q <= '0; sdepth_q <= '0;
                root_q <= NW'(1); comp_q <= '0; any_q <= 1'b0;
                state_q <= StP1Start;
              end
            endcase
          end
        end
        StEditRd: state_q <= StEditWr;
        StEditWr: state_q <= StIdle;
        StClear: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == (IW+1)'(N - 1)) state_q <= StIdle;
        end
        StP1Start: begin
          // Stack empty: pick next unvisited root, else go to pass two.
          if (sdepth_q == '0) begin
            if (root_q > n_eff) begin
              visited_q <= '0; state_q <= StP2Pop;
            end else begin
              root_q <= root_q + 1'b1;
              if (!visited_q[IW'(root_q - 1'b1)]) begin
                visited_q[IW'(root_q - 1'b1)] <= 1'b1;
                snode_q[0] <= root_q; spos_q[0] <= '0; sdepth_q <= (IW+1)'(1);
              end
            end
          end else begin
            state_q <= StP1Scan;   // row of top issued this cycle
          end
        end
        StP1Rd: state_q <= StP1Scan;
        StP1Scan: begin
          if (found) begin
            spos_q[top] <= fnd;
            visited_q[IW'(fnd - 1'b1)] <= 1'b1;
            snode_q[IW'(sdepth_q)] <= fnd; spos_q[IW'(sdepth_q)] <= '0;
            sdepth_q <= sdepth_q + 1'b1;
            state_q <= StP1Rd;
          end else begin
            fstack_q[IW'(fcount_q)] <= tnode;
            fcount_q <= fcount_q + 1'b1;
            sdepth_q <= sdepth_q - 1'b1;
            state_q <= StP1Start;
          end
        end
        StP2Pop: begin
          if (!ostall) begin
            if (fcount_q == '0) begin
              if (any_q) begin
                out_q <= '{node: pend_q.node, comp: pend_q.comp, eoc: 1'b1, last: 1'b1};
              end
              state_q <= StIdle;
            end else begin
              fcount_q <= fcount_q - 1'b1;
              if (pop_new) begin
                visited_q[IW'(pop_node - 1'b1)] <= 1'b1;
                snode_q[0] <= pop_node;
                spos_q[0] <= '0; sdepth_q <= (IW+1)'(1);
                if (any_q) begin
                  out_q <= pend_q;
                end
                pend_q <= '{node: pop_node, comp: comp_q, eoc: 1'b0, last: 1'b0};
                any_q <= 1'b1;
                state_q <= StP2Next;
              end
            end
          end
        end
        StP2Next: begin
          // Test candidate u = tpos+1 on the transpose: read row u-1, bit tnode-1.
          if (sdepth_q == '0) begin
            pend_q.eoc <= 1'b1; comp_q <= comp_q + 1'b1; state_q <= StP2Pop;
          end else if (tpos >= n_eff) begin
            sdepth_q <= sdepth_q - 1'b1;
          end else begin
            state_q <= StP2Rd;
          end
        end
        StP2Rd: state_q <= StP2Scan;
        StP2Scan: begin
          if (!ostall) begin
            spos_q[top] <= tpos + 1'b1;
            if (scan_hit) begin
              visited_q[IW'(tpos)] <= 1'b1;
              snode_q[IW'(sdepth_q)] <= tpos + 1'b1; spos_q[IW'(sdepth_q)] <= '0;
              sdepth_q <= sdepth_q + 1'b1;
              out_q <= pend_q;
              pend_q <= '{node: tpos + 1'b1, comp: comp_q, eoc: 1'b0, last: 1'b0};
            end
            state_q <= StP2Next;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // The output register is never overwritten while it still holds a result.
  `SCC_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, ostall, ##1 (valid_o && $stable(node_o)))
  // The search stack never grows past MaxNodes entries.
  `SCC_ASSERT_IMP(a_depth_bound, clk_i, rst_ni, 1'b1, sdepth_q <= (IW+1)'(N))
  // Requests are taken only when idle.
  `SCC_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, ready_o, state_q == StIdle)
endmodule

// ===== hdl/scc_ram.sv =====
module scc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
